// File: rtl/core/sect_xlat_pkg.sv
`timescale 1ns / 1ps

package sect_xlat_pkg;

  localparam int NUM_SECTIONS      = 18;
  localparam int NUM_TEXT_SECTIONS = 7;
  localparam int TEXT_CNT          = (NUM_TEXT_SECTIONS > NUM_SECTIONS) ?
                                     NUM_SECTIONS : NUM_TEXT_SECTIONS;
  localparam int IDX_W             = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int CNT_W             = $clog2(NUM_SECTIONS + 1);

  localparam logic [31:0] ALIGN_MASK      = 32'd3;
  localparam logic [31:0] MIN_OFFSET_RST  = 32'd256;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_ADDR2OFF  = 3'd1,
    OP_OFF2ADDR  = 3'd2,
    OP_OVERLAP   = 3'd3,
    OP_FIND_FREE = 3'd4,
    OP_VALIDATE  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_ALL_TEXT_FIRST = 2'd0,
    MODE_TEXT_ONLY      = 2'd1,
    MODE_DATA_ONLY      = 2'd2,
    MODE_ALL_DATA_FIRST = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  sect_index;
    logic [31:0] entry_offset;
    logic [31:0] entry_size;
    logic [31:0] entry_load_addr;
    logic [31:0] query_key;
    logic [31:0] query_size;
    logic [1:0]  search_mode;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] result_value;
    logic [4:0]  overlap_count;
    logic [4:0]  free_index;
  } result_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] load_addr;
  } entry_t;

  typedef entry_t [NUM_SECTIONS-1:0] table_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wr_req_t;

endpackage

// File: rtl/core/section_table_address_translator_unit.sv
`timescale 1ns / 1ps

// Section table address translator. Holds a table of eighteen sections (file
// offset, size, load address; the first seven are text, the rest data), all
// cleared by reset. Each input transfer carries one operation: write an entry,
// translate an address to a file offset or back through the first entry that
// holds the whole range, count overlapped entries, find the first empty entry
// in the order the search mode selects, or validate the table as a header.
// Every input transfer yields exactly one result transfer. The unit takes one
// item per cycle while the result channel does not stall; an item passes an
// input register and a result register, with the parallel table compare
// between them, and waits only while the result channel stalls. A written
// entry is seen by the very next item. The header size register is written
// through the configuration channel, which is always ready.

module section_table_address_translator_unit
  import sect_xlat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic        item_valid_q;
  item_t       item_q;
  logic        res_valid_q;
  result_t     res_q;
  logic [31:0] min_offset_q;
  logic        advance;
  logic        fire;
  table_t      tbl;
  result_t     res_d;
  wr_req_t     eval_wr;
  wr_req_t     tbl_wr;

  assign advance    = !res_valid_q || out_ready_i;
  assign fire       = item_valid_q && advance;
  assign in_ready_o = !item_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_offset_q <= MIN_OFFSET_RST;
    end else if (cfg_valid_i) begin
      min_offset_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  sect_xlat_eval u_eval (
    .item_i       (item_q),
    .table_i      (tbl),
    .min_offset_i (min_offset_q),
    .result_o     (res_d),
    .wr_o         (eval_wr)
  );

  always_comb begin
    tbl_wr    = eval_wr;
    tbl_wr.en = eval_wr.en && fire;
  end

  sect_xlat_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tbl_wr),
    .table_o (tbl)
  );

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

// File: rtl/core/sect_xlat_table.sv
`timescale 1ns / 1ps

module sect_xlat_table
  import sect_xlat_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  wr_req_t wr_i,
  output table_t  table_o
);

  table_t tbl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q <= '0;
    end else if (wr_i.en) begin
      tbl_q[wr_i.idx] <= wr_i.entry;
    end
  end

  assign table_o = tbl_q;

endmodule

// File: rtl/core/sect_xlat_eval.sv
`timescale 1ns / 1ps

module sect_xlat_eval
  import sect_xlat_pkg::*;
(
  input  item_t       item_i,
  input  table_t      table_i,
  input  logic [31:0] min_offset_i,
  output result_t     result_o,
  output wr_req_t     wr_o
);

  logic [31:0]             qend;
  logic [32:0]             qsum;
  logic [31:0]             ov_end;
  logic [NUM_SECTIONS-1:0] match;
  logic [NUM_SECTIONS-1:0] overlap;
  logic [NUM_SECTIONS-1:0] empty;
  logic [NUM_SECTIONS-1:0] text_mask;
  logic [NUM_SECTIONS-1:0] entry_ok;
  logic                    xl_hit;
  logic [31:0]             xl_base;
  logic [31:0]             xl_other;
  logic [31:0]             xl_value;
  logic                    txt_found;
  logic [IDX_W-1:0]        txt_idx;
  logic                    dat_found;
  logic [IDX_W-1:0]        dat_idx;
  logic                    all_found;
  logic [IDX_W-1:0]        all_idx;
  logic [CNT_W-1:0]        ov_cnt;
  logic                    valid_hdr;
  logic                    use_load;
  logic [31:0]             base_i;
  logic [31:0]             osum;

  assign qsum     = {1'b0, item_i.query_key} + {1'b0, item_i.query_size};
  assign qend     = qsum[31:0];
  assign ov_end   = qsum[32] ? 32'hFFFF_FFFF : qsum[31:0];
  assign use_load = (item_i.op == OP_ADDR2OFF);

  always_comb begin
    match     = '0;
    overlap   = '0;
    empty     = '0;
    text_mask = '0;
    entry_ok  = '0;
    base_i    = '0;
    osum      = '0;
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      base_i  = use_load ? table_i[i].load_addr : table_i[i].offset;
      match[i] = (item_i.query_key >= base_i) &&
                 (qend <= 32'(base_i + table_i[i].size));
      overlap[i] = (item_i.query_key < 32'(table_i[i].load_addr + table_i[i].size)) &&
                   (ov_end > table_i[i].load_addr);
      empty[i]     = (table_i[i].size == '0);
      text_mask[i] = (i < TEXT_CNT);
      osum         = 32'(table_i[i].offset + table_i[i].size);
      entry_ok[i]  = ((table_i[i].offset == '0) && (table_i[i].size == '0) &&
                      (table_i[i].load_addr == '0)) ||
                     ((((table_i[i].offset | table_i[i].size | table_i[i].load_addr) &
                        ALIGN_MASK) == '0) &&
                      (table_i[i].offset >= min_offset_i) &&
                      ((item_i.query_key == '0) || (osum <= item_i.query_key)));
    end
  end

  always_comb begin
    xl_hit   = 1'b0;
    xl_base  = '0;
    xl_other = '0;
    for (int i = NUM_SECTIONS - 1; i >= 0; i--) begin
      if (match[i]) begin
        xl_hit   = 1'b1;
        xl_base  = use_load ? table_i[i].load_addr : table_i[i].offset;
        xl_other = use_load ? table_i[i].offset : table_i[i].load_addr;
      end
    end
  end

  assign xl_value = 32'(xl_other + (item_i.query_key - xl_base));

  always_comb begin
    txt_found = 1'b0;
    txt_idx   = '0;
    dat_found = 1'b0;
    dat_idx   = '0;
    all_found = 1'b0;
    all_idx   = '0;
    ov_cnt    = '0;
    for (int i = NUM_SECTIONS - 1; i >= 0; i--) begin
      if (empty[i]) begin
        all_found = 1'b1;
        all_idx   = IDX_W'(i);
        if (text_mask[i]) begin
          txt_found = 1'b1;
          txt_idx   = IDX_W'(i);
        end else begin
          dat_found = 1'b1;
          dat_idx   = IDX_W'(i);
        end
      end
    end
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      ov_cnt = ov_cnt + CNT_W'(overlap[i]);
    end
  end

  assign valid_hdr = (item_i.query_size >= min_offset_i) && (&entry_ok);

  always_comb begin
    result_o = '0;
    case (item_i.op)
      OP_ADDR2OFF, OP_OFF2ADDR: begin
        result_o.hit          = xl_hit;
        result_o.result_value = xl_hit ? xl_value : '0;
      end
      OP_OVERLAP: begin
        result_o.overlap_count = 5'(ov_cnt);
      end
      OP_FIND_FREE: begin
        case (item_i.search_mode)
          MODE_ALL_TEXT_FIRST: begin
            result_o.hit        = all_found;
            result_o.free_index = all_found ? 5'(all_idx) : '0;
          end
          MODE_TEXT_ONLY: begin
            result_o.hit        = txt_found;
            result_o.free_index = txt_found ? 5'(txt_idx) : '0;
          end
          MODE_DATA_ONLY: begin
            result_o.hit        = dat_found;
            result_o.free_index = dat_found ? 5'(dat_idx) : '0;
          end
          MODE_ALL_DATA_FIRST: begin
            result_o.hit        = dat_found || txt_found;
            result_o.free_index = dat_found ? 5'(dat_idx) :
                                  (txt_found ? 5'(txt_idx) : '0);
          end
          default: begin
            result_o.hit = 1'b0;
          end
        endcase
      end
      OP_VALIDATE: begin
        result_o.hit = valid_hdr;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  always_comb begin
    wr_o                 = '0;
    wr_o.en              = (item_i.op == OP_WRITE) &&
                           (32'(item_i.sect_index) < 32'(NUM_SECTIONS));
    wr_o.idx             = IDX_W'(item_i.sect_index);
    wr_o.entry.offset    = item_i.entry_offset;
    wr_o.entry.size      = item_i.entry_size;
    wr_o.entry.load_addr = item_i.entry_load_addr;
  end

endmodule

// File: verif/section_table_address_translator_checker.sv
`timescale 1ns / 1ps

module section_table_address_translator_checker
  import sect_xlat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  item_t       in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  result_t     out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  localparam int REPORT_LIMIT = 10;

  logic [31:0] tbl_off  [NUM_SECTIONS];
  logic [31:0] sect_len [NUM_SECTIONS];
  logic [31:0] tbl_addr [NUM_SECTIONS];
  logic [31:0] hdr_min;
  result_t     expected_results [$];
  result_t     oldest;

  function automatic logic first_empty(input int lo, input int hi, output logic [4:0] idx);
    idx = '0;
    for (int i = lo; i < hi; i++) begin
      if (sect_len[i] == 32'd0) begin
        idx = 5'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic translate(input logic by_addr, input logic [31:0] key,
                                     input logic [31:0] len, output logic [31:0] res);
    logic [31:0] base, other, qend, send;
    res  = '0;
    qend = key + len;
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      base  = by_addr ? tbl_addr[i] : tbl_off[i];
      other = by_addr ? tbl_off[i] : tbl_addr[i];
      send  = base + sect_len[i];
      if (key >= base && qend <= send) begin
        res = other + (key - base);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [4:0] overlap_total(input logic [31:0] key, input logic [31:0] len);
    logic [31:0] qend, send;
    int          n;
    n    = 0;
    qend = key + len;
    if (qend < key) qend = '1;
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      send = tbl_addr[i] + sect_len[i];
      if (key < send && qend > tbl_addr[i]) n++;
    end
    return 5'(n);
  endfunction

  function automatic logic header_valid(input logic [31:0] img_bytes, input logic [31:0] avail);
    logic [31:0] o, s, a, e;
    if (avail < hdr_min) return 1'b0;
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      o = tbl_off[i];
      s = sect_len[i];
      a = tbl_addr[i];
      if (o == 32'd0 && s == 32'd0 && a == 32'd0) continue;
      if (((o | s | a) & ALIGN_MASK) != 32'd0) return 1'b0;
      if (o < hdr_min) return 1'b0;
      e = o + s;
      if (img_bytes != 32'd0 && e > img_bytes) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_result(input item_t it);
    result_t     r;
    logic [31:0] val;
    logic [4:0]  idx;
    r   = '0;
    idx = '0;
    case (it.op)
      OP_WRITE: begin
        if (it.sect_index < NUM_SECTIONS) begin
          tbl_off[it.sect_index]  = it.entry_offset;
          sect_len[it.sect_index] = it.entry_size;
          tbl_addr[it.sect_index] = it.entry_load_addr;
        end
      end
      OP_ADDR2OFF, OP_OFF2ADDR: begin
        r.hit = translate(it.op == OP_ADDR2OFF, it.query_key, it.query_size, val);
        r.result_value = val;
      end
      OP_OVERLAP: r.overlap_count = overlap_total(it.query_key, it.query_size);
      OP_FIND_FREE: begin
        case (it.search_mode)
          MODE_ALL_TEXT_FIRST: r.hit = first_empty(0, NUM_SECTIONS, idx);
          MODE_TEXT_ONLY:      r.hit = first_empty(0, TEXT_CNT, idx);
          MODE_DATA_ONLY:      r.hit = first_empty(TEXT_CNT, NUM_SECTIONS, idx);
          MODE_ALL_DATA_FIRST: begin
            r.hit = first_empty(TEXT_CNT, NUM_SECTIONS, idx);
            if (!r.hit) r.hit = first_empty(0, TEXT_CNT, idx);
          end
          default: r.hit = 1'b0;
        endcase
        r.free_index = idx;
      end
      OP_VALIDATE: r.hit = header_valid(it.query_key, it.query_size);
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input result_t exp_r, input result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("%0t %s: expected hit=%0b value=%h overlaps=%0d free=%0d", $time, what,
               exp_r.hit, exp_r.result_value, exp_r.overlap_count, exp_r.free_index);
      $display("    actual hit=%0b value=%h overlaps=%0d free=%0d",
               got.hit, got.result_value, got.overlap_count, got.free_index);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_min = MIN_OFFSET_RST;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        tbl_off[i]  = '0;
        sect_len[i] = '0;
        tbl_addr[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", '0, out_data_i);
        end else begin
          oldest = expected_results.pop_front();
          if (out_data_i.hit !== oldest.hit ||
              out_data_i.result_value !== oldest.result_value ||
              out_data_i.overlap_count !== oldest.overlap_count ||
              out_data_i.free_index !== oldest.free_index)
            report("result mismatch", oldest, out_data_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) hdr_min = cfg_data_i;
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_result(in_data_i));
    end
    pending_count_o = expected_results.size();
  end

endmodule

// File: verif/section_table_address_translator_unit_tb.sv
`timescale 1ns / 1ps

module section_table_address_translator_unit_tb;
  import sect_xlat_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int         PHASES           = 6;
  localparam int         RANDOM_PER_PHASE = 160;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  item_t       in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  int          mismatches;
  int          pending;
  bit          no_idle   = 1'b0;
  logic [31:0] cur_hdr   = MIN_OFFSET_RST;
  logic [31:0] gen_off  [NUM_SECTIONS] = '{default: '0};
  logic [31:0] gen_len  [NUM_SECTIONS] = '{default: '0};
  logic [31:0] gen_addr [NUM_SECTIONS] = '{default: '0};

  section_table_address_translator_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  section_table_address_translator_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.op              = 3'($urandom);
    it.sect_index      = 5'($urandom);
    it.entry_offset    = $urandom;
    it.entry_size      = $urandom;
    it.entry_load_addr = $urandom;
    it.query_key       = $urandom;
    it.query_size      = $urandom;
    it.search_mode     = 2'($urandom);
    return it;
  endfunction

  function automatic item_t write_of(input int idx, input logic [31:0] off,
                                     input logic [31:0] size, input logic [31:0] addr);
    item_t it;
    it                 = noise_item();
    it.op              = OP_WRITE;
    it.sect_index      = 5'(idx);
    it.entry_offset    = off;
    it.entry_size      = size;
    it.entry_load_addr = addr;
    return it;
  endfunction

  function automatic item_t query_of(input logic [2:0] op, input logic [31:0] key,
                                     input logic [31:0] len, input mode_e mode);
    item_t it;
    it             = noise_item();
    it.op          = op;
    it.query_key   = key;
    it.query_size  = len;
    it.search_mode = mode;
    return it;
  endfunction

  function automatic item_t sane_write(input int idx);
    logic [31:0] floor_off, addr;
    floor_off = (cur_hdr + 32'd3) & ~ALIGN_MASK;
    if ($urandom_range(0, 9) == 0)
      addr = 32'hFFFF_F000 + 32'($urandom_range(0, 'h3FF)) * 4;
    else
      addr = 32'h8000_0000 + 32'($urandom_range(0, 'h4000)) * 4;
    return write_of(idx, floor_off + 32'($urandom_range(0, 'h4000)) * 4,
                    32'($urandom_range(1, 'h400)) * 4, addr);
  endfunction

  function automatic item_t lookup_item(input logic [2:0] op);
    item_t       it;
    int          j;
    logic [31:0] base, span;
    it    = noise_item();
    it.op = op;
    if ($urandom_range(0, 9) < 7) begin
      j             = $urandom_range(0, NUM_SECTIONS - 1);
      base          = (op == OP_OFF2ADDR) ? gen_off[j] : gen_addr[j];
      span          = $urandom_range(0, gen_len[j]);
      it.query_key  = base + span;
      it.query_size = $urandom_range(0, gen_len[j] - span);
      if ($urandom_range(0, 3) == 0) it.query_size = it.query_size + 32'd1;
    end else if ($urandom_range(0, 1) == 0) begin
      it.query_size = 32'($urandom_range(0, 64));
    end
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    int    idx;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      if ($urandom_range(0, 6) == 0) idx = $urandom_range(NUM_SECTIONS, 31);
      else idx = $urandom_range(0, NUM_SECTIONS - 1);
      it = sane_write(idx);
      case ($urandom_range(0, 7))
        0: begin
          it.entry_offset    = '0;
          it.entry_size      = '0;
          it.entry_load_addr = '0;
        end
        1: it.entry_size = '0;
        2, 3: begin
          it.entry_offset    = $urandom;
          it.entry_size      = $urandom;
          it.entry_load_addr = $urandom;
        end
        default: it.op = OP_WRITE;
      endcase
    end else if (r < 40) begin
      it = lookup_item(OP_ADDR2OFF);
    end else if (r < 58) begin
      it = lookup_item(OP_OFF2ADDR);
    end else if (r < 72) begin
      it = lookup_item(OP_OVERLAP);
    end else if (r < 82) begin
      it    = noise_item();
      it.op = OP_FIND_FREE;
    end else if (r < 94) begin
      it    = noise_item();
      it.op = OP_VALIDATE;
      case ($urandom_range(0, 3))
        0: it.query_key = '0;
        1: it.query_key = cur_hdr + 32'($urandom_range(0, 'h12000));
        2: it.query_key = cur_hdr + 32'h0001_2000;
        default: it.op = OP_VALIDATE;
      endcase
      if ($urandom_range(0, 3) != 0)
        it.query_size = cur_hdr + 32'($urandom_range(0, 2)) - 32'd1;
    end else begin
      it    = noise_item();
      it.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    end
    return it;
  endfunction

  // enter and leave at a falling edge; valid stays high when no gap is due
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (it.op == OP_WRITE && it.sect_index < NUM_SECTIONS) begin
      gen_off[it.sect_index]  = it.entry_offset;
      gen_len[it.sect_index]  = it.entry_size;
      gen_addr[it.sect_index] = it.entry_load_addr;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_hdr(input logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_hdr = value;
  endtask

  initial begin
    int run;
    int gap;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 24);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [31:0] hdr_plan [PHASES];
    hdr_plan = '{MIN_OFFSET_RST, 32'h0, 32'hFFFF_FFFF, 32'h0000_0004,
                 $urandom & ~ALIGN_MASK, $urandom};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(query_of(OP_VALIDATE, 32'd0, 32'd256, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_VALIDATE, 32'd0, 32'd255, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_FIND_FREE, '0, '0, MODE_ALL_DATA_FIRST));
    send_item(write_of(0, 32'h100, 32'h100, 32'h8000_0000));
    send_item(write_of(NUM_SECTIONS - 1, 32'h1000, 32'h40, 32'hFFFF_FFF0));
    send_item(write_of(TEXT_CNT - 1, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'h4));
    send_item(write_of(NUM_SECTIONS, '1, '1, '1));
    send_item(write_of(31, '1, '1, '1));
    send_item(query_of(OP_ADDR2OFF, 32'h8000_0010, 32'h10, MODE_TEXT_ONLY));
    send_item(query_of(OP_ADDR2OFF, 32'h8000_00F0, 32'h20, MODE_TEXT_ONLY));
    send_item(query_of(OP_OFF2ADDR, 32'h100, 32'h0, MODE_DATA_ONLY));
    send_item(query_of(OP_OFF2ADDR, '1, '1, MODE_DATA_ONLY));
    send_item(query_of(OP_OVERLAP, 32'hFFFF_FFF0, 32'h20, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_OVERLAP, 32'h0, 32'h0, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_OVERLAP, 32'h0, '1, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_FIND_FREE, '1, '1, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_FIND_FREE, '1, '1, MODE_TEXT_ONLY));
    send_item(query_of(OP_FIND_FREE, '1, '1, MODE_DATA_ONLY));
    send_item(query_of(OP_VALIDATE, 32'h0, '1, MODE_ALL_TEXT_FIRST));
    send_item(query_of(OP_VALIDATE, 32'h2000, 32'h100, MODE_ALL_TEXT_FIRST));
    send_item(write_of(8, 32'h102, 32'h4, 32'h8));
    send_item(query_of(OP_VALIDATE, 32'h0, 32'h100, MODE_ALL_TEXT_FIRST));
    send_item(write_of(0, '0, '0, '0));
    send_item(query_of(OP_SPARE_A, '1, '1, MODE_ALL_DATA_FIRST));
    send_item(query_of(OP_SPARE_B, '1, '1, MODE_ALL_DATA_FIRST));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_hdr(hdr_plan[p]);
      no_idle = (p == 1);
      for (int i = 0; i < NUM_SECTIONS; i++) send_item(sane_write(i));
      send_item(query_of(OP_VALIDATE, cur_hdr + 32'h0001_2000, cur_hdr, MODE_ALL_TEXT_FIRST));
      send_item(query_of(OP_FIND_FREE, '0, '0, MODE_ALL_TEXT_FIRST));
      send_item(query_of(OP_FIND_FREE, '0, '0, MODE_TEXT_ONLY));
      send_item(query_of(OP_FIND_FREE, '0, '0, MODE_DATA_ONLY));
      send_item(query_of(OP_FIND_FREE, '0, '0, MODE_ALL_DATA_FIRST));
      repeat (RANDOM_PER_PHASE) send_item(random_item());
    end

    no_idle = 1'b0;
    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
